### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SEG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, also checked through reset.
`define SEG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/seg_pkg.sv
// ----------------------------------------------------------------------------
// seg_pkg
// Types and constants shared by the exposure/gain metadata pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package seg_pkg;

    localparam int D_W  = 36;   // exposure divisor: pixel clock * 16
    localparam int Q_W  = 32;   // quotient bits, one per divider stage
    localparam int GD_W = 11;   // analog gain divisor: 2 * (1024 - code)

    localparam logic [12:0] ANA_LO = 13'd112;
    localparam logic [12:0] ANA_HI = 13'd1008;
    localparam logic [12:0] DIG_LO = 13'd1264;
    localparam logic [12:0] DIG_HI = 13'd5103;
    localparam logic [10:0] ANA_BASE  = 11'd1024;
    localparam logic [20:0] ANA_NUM   = 21'd2048000;
    localparam logic [7:0]  DIG_STEP  = 8'd250;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD      = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_BAD_GAIN = 2'd3;

    localparam logic [1:0] REG_WIDTH = 2'd0;
    localparam logic [1:0] REG_HBLANK = 2'd1;
    localparam logic [1:0] REG_PRATE = 2'd2;

    typedef struct packed {
        logic [15:0] line_act;
        logic [15:0] line_blank;
        logic [31:0] pclk_rate;
    } t_cfg;

    typedef struct packed {
        logic            bad_setup;
        logic            over;
        logic            gain_ok;
        logic            gain_analog;
        logic [19:0]     gain_dig;
        logic [GD_W-1:0] g_div;
    } t_meta;

    typedef struct packed {
        t_meta           meta;
        logic [D_W-1:0]  r_exp;
        logic [Q_W-1:0]  lo_exp;
        logic [Q_W-1:0]  q_exp;
        logic [GD_W-1:0] r_g;
        logic [Q_W-1:0]  lo_g;
        logic [Q_W-1:0]  q_g;
    } t_div_st;

endpackage

`default_nettype wire

### rtl/seg_cfg.sv
// ----------------------------------------------------------------------------
// seg_cfg
// APB register file: active width, horizontal blanking, pixel clock rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module seg_cfg
    import seg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= {16'd4000, 16'd4976, 32'd678400000};
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_WIDTH:  r_cfg.line_act   <= pwdata[15:0];
                REG_HBLANK: r_cfg.line_blank <= pwdata[15:0];
                REG_PRATE:  r_cfg.pclk_rate  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = {16'd0, r_cfg.line_act};
            REG_HBLANK: prdata = {16'd0, r_cfg.line_blank};
            REG_PRATE:  prdata = r_cfg.pclk_rate;
            default:    prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/seg_front.sv
// ----------------------------------------------------------------------------
// seg_front
// Four stages: line product, split constant multiply, sum, range check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module seg_front
    import seg_pkg::*;
#(
    parameter int EXPOSURE_WIDTH = 20
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_adv,
    input  wire logic                      i_valid,
    input  wire logic [EXPOSURE_WIDTH-1:0] i_exposure_sixteenths,
    input  wire logic [12:0]               i_gain_code,
    input  t_cfg                           i_cfg,
    output logic                           o_valid,
    output t_div_st                        o_data
);

    localparam int X_W    = EXPOSURE_WIDTH + 17;
    localparam int LO_W   = X_W / 2;
    localparam int HI_W   = X_W - LO_W;
    localparam int PLO_W  = LO_W + 14;
    localparam int PHI_W  = HI_W + 14;
    localparam int N_W    = X_W + 20;
    localparam int LIM_W  = D_W + Q_W;
    localparam int CMP_W  = (N_W > LIM_W) ? N_W : LIM_W;
    localparam logic [13:0] K_MUL = 14'd15625;   // 1e6 = 15625 * 64

    logic [3:0]       r_vld;
    t_meta            r_m1, r_m2, r_m3;
    logic [X_W-1:0]   r_x;
    logic [PLO_W-1:0] r_p_lo;
    logic [PHI_W-1:0] r_p_hi;
    logic [N_W-1:0]   r_n;
    t_div_st          r_out;

    logic [16:0]      w_line;
    logic             w_ana;
    logic             w_dig;
    logic [9:0]       w_den;
    logic [12:0]      w_dig_off;
    t_meta            w_m0;
    t_meta            w_m4;
    t_div_st          w_out;
    logic [D_W-1:0]   w_d;
    logic [LIM_W-1:0] w_lim;
    logic [N_W-1:0]   w_n;

    always_comb begin
        w_line    = {1'b0, i_cfg.line_act} + {1'b0, i_cfg.line_blank};
        w_ana     = (i_gain_code >= ANA_LO) && (i_gain_code <= ANA_HI);
        w_dig     = (i_gain_code >= DIG_LO) && (i_gain_code <= DIG_HI);
        w_den     = 10'(ANA_BASE - 11'(i_gain_code));
        w_dig_off = i_gain_code - ANA_HI;
        w_m0.bad_setup   = (i_exposure_sixteenths == '0) || (i_cfg.line_act == '0)
                           || (i_cfg.pclk_rate == '0);
        w_m0.over        = 1'b0;
        w_m0.gain_ok     = w_ana || w_dig;
        w_m0.gain_analog = w_ana;
        w_m0.gain_dig    = 20'(20'(w_dig_off) * 20'(DIG_STEP));
        w_m0.g_div       = {w_den, 1'b0};
        w_d   = {i_cfg.pclk_rate, 4'd0};
        w_lim = {w_d, {Q_W{1'b0}}} - LIM_W'(w_d);
        w_n   = ((N_W'(r_p_hi) << LO_W) + N_W'(r_p_lo)) << 6;
        // range check and divider seed
        w_m4         = r_m3;
        w_m4.over    = CMP_W'(r_n) > CMP_W'(w_lim);
        w_out        = '0;
        w_out.meta   = w_m4;
        w_out.r_exp  = D_W'(r_n >> Q_W);
        w_out.lo_exp = r_n[Q_W-1:0];
        w_out.lo_g   = Q_W'(ANA_NUM + 21'(r_m3.g_div[GD_W-1:1]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // line product
            r_x  <= X_W'(i_exposure_sixteenths) * X_W'(w_line);
            r_m1 <= w_m0;
            // constant multiply in two halves
            r_p_lo <= PLO_W'(r_x[LO_W-1:0]) * PLO_W'(K_MUL);
            r_p_hi <= PHI_W'(r_x[X_W-1:LO_W]) * PHI_W'(K_MUL);
            r_m2   <= r_m1;
            // combine
            r_n  <= w_n;
            r_m3 <= r_m2;
            r_out <= w_out;
        end
    end

    assign o_valid = r_vld[3];
    assign o_data  = r_out;

endmodule

`default_nettype wire

### rtl/seg_div_stage.sv
// ----------------------------------------------------------------------------
// seg_div_stage
// One restoring division step for both the exposure and analog gain quotients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module seg_div_stage
    import seg_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire logic           i_valid,
    input  t_div_st             i_data,
    input  wire logic [D_W-1:0] i_divisor,
    output logic                o_valid,
    output t_div_st             o_data
);

    logic [D_W:0]    w_t;
    logic            w_ge;
    logic [GD_W:0]   w_tg;
    logic            w_geg;
    t_div_st         w_nx;

    always_comb begin
        w_t   = {i_data.r_exp, i_data.lo_exp[Q_W-1]};
        w_ge  = w_t >= {1'b0, i_divisor};
        w_tg  = {i_data.r_g, i_data.lo_g[Q_W-1]};
        w_geg = w_tg >= {1'b0, i_data.meta.g_div};
        w_nx        = i_data;
        w_nx.r_exp  = w_ge ? D_W'(w_t - {1'b0, i_divisor}) : w_t[D_W-1:0];
        w_nx.lo_exp = {i_data.lo_exp[Q_W-2:0], 1'b0};
        w_nx.q_exp  = {i_data.q_exp[Q_W-2:0], w_ge};
        w_nx.r_g    = w_geg ? GD_W'(w_tg - {1'b0, i_data.meta.g_div}) : w_tg[GD_W-1:0];
        w_nx.lo_g   = {i_data.lo_g[Q_W-2:0], 1'b0};
        w_nx.q_g    = {i_data.q_g[Q_W-2:0], w_geg};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_data <= w_nx;
        end
    end

endmodule

`default_nettype wire

### rtl/seg_back.sv
// ----------------------------------------------------------------------------
// seg_back
// Round, pick gain, set status; then ISO scale into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module seg_back
    import seg_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire logic           i_valid,
    input  t_div_st             i_data,
    input  wire logic [D_W-1:0] i_divisor,
    output logic                o_valid,
    output logic [31:0]         o_exp_usec,
    output logic [19:0]         o_gain_milli,
    output logic [15:0]         o_iso_value,
    output logic [1:0]          o_status
);

    localparam logic [19:0] RECIP5 = 20'd838861;   // ceil(2^22 / 5)

    logic        r_vld1;
    logic [31:0] r_us;
    logic [19:0] r_g;
    logic [1:0]  r_st;

    logic        w_rnd;
    logic [31:0] w_us;
    logic [1:0]  w_st;
    logic [19:0] w_g;
    logic [17:0] w_v;
    logic [37:0] w_prod;

    always_comb begin
        w_rnd = {i_data.r_exp, 1'b0} >= {1'b0, i_divisor};
        w_us  = i_data.q_exp + 32'(w_rnd);
        if (i_data.meta.bad_setup) begin
            w_st = ST_BAD;
        end else if (i_data.meta.over || (w_us == '0)) begin
            w_st = ST_RANGE;
        end else if (!i_data.meta.gain_ok) begin
            w_st = ST_BAD_GAIN;
        end else begin
            w_st = ST_OK;
        end
        w_g    = i_data.meta.gain_analog ? i_data.q_g[19:0] : i_data.meta.gain_dig;
        // iso = floor((g + 10) / 20)
        w_v    = 18'((r_g + 20'd10) >> 2);
        w_prod = 38'(w_v) * 38'(RECIP5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1  <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_adv) begin
            r_vld1  <= i_valid;
            o_valid <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_st          <= w_st;
            r_us          <= (w_st == ST_OK) ? w_us : '0;
            r_g           <= (w_st == ST_OK) ? w_g : '0;
            o_exp_usec    <= r_us;
            o_gain_milli  <= r_g;
            o_iso_value   <= w_prod[37:22];
            o_status      <= r_st;
        end
    end

endmodule

`default_nettype wire

### rtl/sensor_exposure_gain_to_metadata.sv
// ----------------------------------------------------------------------------
// sensor_exposure_gain_to_metadata
// Converts exposure and gain snapshots to microseconds, milli-gain and ISO.
// Usage:
//   Input channel (i_valid / o_stall) carries one exposure in 1/16 lines and
//   one sensor gain code per transfer. Output channel (o_valid / i_stall)
//   returns exposure in us, gain_milli, iso_value and status for every input.
//   Line timing and pixel clock come from the APB registers; write them only
//   while no transfer is in flight.
//   The pipeline has 4 front stages (line product, split multiply by
//   1e6, sum, range check), 32 restoring divider stages that each resolve one
//   quotient bit of both the exposure and the analog gain division, and 2
//   back stages (rounding/status, ISO scale into the output register).
//   Throughput is one transfer per cycle; the divider chain sets the latency
//   and only a receiver stall limits the rate.
//   When the receiver stalls while a result is held, the whole pipeline holds
//   and o_stall rises; nothing is dropped or repeated.
//   Reset clears all valid bits and loads the register defaults
//   (width 4000, blanking 4976, pixel clock 678400000).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sensor_exposure_gain_to_metadata
    import seg_pkg::*;
#(
    parameter int EXPOSURE_WIDTH = 20
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // input channel
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [EXPOSURE_WIDTH-1:0] i_exposure_sixteenths,
    input  wire logic [12:0]               i_gain_code,
    // output channel
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [31:0]                    o_exp_usec,
    output logic [19:0]                    o_gain_milli,
    output logic [15:0]                    o_iso_value,
    output logic [1:0]                     o_status,
    // configuration
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [3:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    t_cfg           w_cfg;
    logic           w_adv;
    logic [D_W-1:0] w_divisor;
    logic           w_out_zero;

    logic    w_vld [Q_W+1];
    t_div_st w_dat [Q_W+1];

    // Advance everything unless a held result is being stalled.
    assign w_adv     = !(o_valid && i_stall);
    assign o_stall   = !w_adv;
    assign w_divisor = {w_cfg.pclk_rate, 4'd0};
    assign w_out_zero = (o_exp_usec == '0) && (o_gain_milli == '0) && (o_iso_value == '0);

    seg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    seg_front #(
        .EXPOSURE_WIDTH (EXPOSURE_WIDTH)
    ) u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_adv                 (w_adv),
        .i_valid               (i_valid),
        .i_exposure_sixteenths (i_exposure_sixteenths),
        .i_gain_code           (i_gain_code),
        .i_cfg                 (w_cfg),
        .o_valid               (w_vld[0]),
        .o_data                (w_dat[0])
    );

    // One quotient bit per stage, most significant first.
    for (genvar g = 0; g < Q_W; g++) begin : g_div
        seg_div_stage u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (w_adv),
            .i_valid   (w_vld[g]),
            .i_data    (w_dat[g]),
            .i_divisor (w_divisor),
            .o_valid   (w_vld[g+1]),
            .o_data    (w_dat[g+1])
        );
    end

    seg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_valid       (w_vld[Q_W]),
        .i_data        (w_dat[Q_W]),
        .i_divisor     (w_divisor),
        .o_valid       (o_valid),
        .o_exp_usec    (o_exp_usec),
        .o_gain_milli  (o_gain_milli),
        .o_iso_value   (o_iso_value),
        .o_status      (o_status)
    );

    `SEG_ASSERT_IMP(a_err_zero, o_valid && (o_status != ST_OK), w_out_zero, "error not zeroed")
    `SEG_ASSERT_IMP(a_ok_nonzero, o_valid && (o_status == ST_OK), (o_exp_usec != '0) && (o_gain_milli != '0), "zero good result")
    `SEG_ASSERT_IMP(a_iso_range, o_valid, o_iso_value <= 16'd51188, "ISO value out of range")
    `SEG_ASSERT_NEXT(a_rst_empty, !i_rst_n, !o_valid, "output valid after reset")

endmodule

`default_nettype wire
